### rtl/aapl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared definitions of the averaging ADC linearizer
// Field widths, configuration codes, status codes and inter-module structs.
// ----------------------------------------------------------------------------
package aapl_pkg;

    localparam int SAMPLE_W  = 10;
    localparam int INDEX_W   = 4;
    localparam int VOLT_W    = 10;
    localparam int DIST_W    = 10;
    localparam int DISTO_W   = 11;
    localparam int STATUS_W  = 2;
    localparam int SPR_W     = 7;
    localparam int PIU_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 7;
    localparam int MAG_W     = 21;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int MAX_SAMPLES_DEF = 64;

    localparam logic [SPR_W-1:0] SPR_RESET = 7'd1;
    localparam logic [PIU_W-1:0] PIU_RESET = 5'd16;

    localparam logic [CFG_IDX_W-1:0] CFG_SPR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIU = 1'b1;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_WITHIN = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NEAR   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BEYOND = 2'd2;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

### rtl/aapl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job queue
// Two-entry queue that decouples the accumulating front from the converter.
// ----------------------------------------------------------------------------
module aapl_queue #(
    parameter int W = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic [W-1:0]           i_data,
    input  logic                   i_pop,
    output logic [W-1:0]           o_data,
    output aapl_pkg::t_queue_status o_status
);
    import aapl_pkg::*;

    localparam int DEPTH = 2;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/aapl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input front end
// Accepts items, sums ADC samples and queues table loads and finished sums.
// ----------------------------------------------------------------------------
module aapl_front #(
    parameter int MAX_SAMPLES = aapl_pkg::MAX_SAMPLES_DEF,
    parameter int CNT_W       = $clog2(MAX_SAMPLES + 1),
    parameter int SUM_W       = aapl_pkg::SAMPLE_W + CNT_W
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [aapl_pkg::SPR_W-1:0]      i_spr,
    input  logic                            push,
    input  logic                            i_command,
    input  logic [aapl_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic [aapl_pkg::INDEX_W-1:0]    i_point_index,
    input  logic [aapl_pkg::VOLT_W-1:0]     i_point_voltage,
    input  logic [aapl_pkg::DIST_W-1:0]     i_point_distance,
    input  aapl_pkg::t_queue_status         i_queue_status,
    output logic                            o_job_push,
    output logic                            o_job_load,
    output logic [aapl_pkg::INDEX_W-1:0]    o_job_index,
    output logic [aapl_pkg::VOLT_W-1:0]     o_job_voltage,
    output logic [aapl_pkg::DIST_W-1:0]     o_job_distance,
    output logic [SUM_W-1:0]                o_job_sum,
    output logic [CNT_W-1:0]                o_job_count
);
    import aapl_pkg::*;

    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_taken;
    logic [SUM_W-1:0] n_sum;
    logic [CNT_W-1:0] n_taken;
    logic [CNT_W-1:0] eff_n;
    logic             accept;
    logic             is_sample;
    logic             complete;

    always_comb begin
        if (i_spr == '0) begin
            eff_n = CNT_W'(1);
        end else if (int'(i_spr) > MAX_SAMPLES) begin
            eff_n = CNT_W'(MAX_SAMPLES);
        end else begin
            eff_n = CNT_W'(i_spr);
        end
    end

    assign accept    = push && !i_queue_status.full;
    assign is_sample = (i_command == CMD_SAMPLE);
    assign n_sum     = r_sum + SUM_W'(i_sample);
    assign n_taken   = r_taken + 1'b1;
    assign complete  = (n_taken >= eff_n);

    assign o_job_push     = accept && (!is_sample || complete);
    assign o_job_load     = (i_command == CMD_LOAD);
    assign o_job_index    = i_point_index;
    assign o_job_voltage  = i_point_voltage;
    assign o_job_distance = i_point_distance;
    assign o_job_sum      = n_sum;
    assign o_job_count    = eff_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_taken <= '0;
        end else if (accept && is_sample) begin
            if (complete) begin
                r_sum   <= '0;
                r_taken <= '0;
            end else begin
                r_sum   <= n_sum;
                r_taken <= n_taken;
            end
        end
    end

endmodule

### rtl/aapl_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative divider
// Unsigned restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module aapl_div #(
    parameter int W = 21
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [W-1:0]         i_dividend,
    input  logic [W-1:0]         i_divisor,
    output logic [W-1:0]         o_quotient,
    output aapl_pkg::t_div_status o_status
);
    import aapl_pkg::*;

    localparam int CW = $clog2(W);

    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [W:0]    rem_sh;
    logic [W+1:0]  diff;
    logic          borrow;

    assign rem_sh = {r_rem, r_quo[W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_div};
    assign borrow = diff[W+1];

    assign o_quotient    = r_quo;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[W-2:0], !borrow};
            r_rem <= borrow ? rem_sh[W-1:0] : diff[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

endmodule

### rtl/aapl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Conversion back end
// Writes calibration points, forms the mean, walks the table, interpolates
// and holds the result for transfer.
// ----------------------------------------------------------------------------
module aapl_back #(
    parameter int TABLE_DEPTH = aapl_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_SAMPLES = aapl_pkg::MAX_SAMPLES_DEF,
    parameter int CNT_W       = $clog2(MAX_SAMPLES + 1),
    parameter int SUM_W       = aapl_pkg::SAMPLE_W + CNT_W,
    parameter int JOB_W       = 1 + aapl_pkg::INDEX_W + aapl_pkg::VOLT_W
                                + aapl_pkg::DIST_W + SUM_W + CNT_W
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [aapl_pkg::PIU_W-1:0]       i_piu,
    input  aapl_pkg::t_queue_status          i_queue_status,
    input  logic [JOB_W-1:0]                 i_job,
    output logic                             o_job_pop,
    input  logic                             pop,
    output logic                             empty,
    output logic [aapl_pkg::DISTO_W-1:0]     o_distance,
    output logic [aapl_pkg::STATUS_W-1:0]    o_status
);
    import aapl_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int PT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int DIV_W = (SUM_W > MAG_W) ? SUM_W : MAG_W;
    localparam int ENT_W = VOLT_W + DIST_W;
    localparam int P_SUM = CNT_W;
    localparam int P_DST = P_SUM + SUM_W;
    localparam int P_VLT = P_DST + DIST_W;
    localparam int P_IDX = P_VLT + VOLT_W;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_MEAN   = 8'b0000_0010,
        S_FIRST  = 8'b0000_0100,
        S_WALK   = 8'b0000_1000,
        S_MUL    = 8'b0001_0000,
        S_ISTART = 8'b0010_0000,
        S_IDIV   = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [ENT_W-1:0]      r_mem [TABLE_DEPTH];
    logic [ENT_W-1:0]      r_rd_data;
    logic [SUM_W-1:0]      r_mean;
    logic [IDX_W-1:0]      r_k;
    logic [VOLT_W-1:0]     r_vh;
    logic [DIST_W-1:0]     r_dh;
    logic signed [10:0]    r_mdiff;
    logic signed [10:0]    r_ddiff;
    logic [VOLT_W-1:0]     r_den;
    logic signed [21:0]    r_num;
    logic [DISTO_W-1:0]    r_res_dist;
    logic [STATUS_W-1:0]   r_res_status;
    logic                  r_out_valid;
    logic [DISTO_W-1:0]    r_out_dist;
    logic [STATUS_W-1:0]   r_out_status;

    logic                  job_load;
    logic [INDEX_W-1:0]    job_index;
    logic [VOLT_W-1:0]     job_voltage;
    logic [DIST_W-1:0]     job_distance;
    logic [SUM_W-1:0]      job_sum;
    logic [CNT_W-1:0]      job_count;
    logic                  mem_we;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [PT_W-1:0]       eff_p;
    logic [IDX_W-1:0]      last_idx;
    logic [VOLT_W-1:0]     vl;
    logic [DIST_W-1:0]     dl;
    logic [SUM_W-1:0]      vl_x;
    logic [SUM_W-1:0]      vh_x;
    logic                  out_take;
    logic                  out_load;
    logic                  div_start;
    logic [DIV_W-1:0]      div_dividend;
    logic [DIV_W-1:0]      div_divisor;
    logic [DIV_W-1:0]      div_q;
    t_div_status           div_st;
    logic [21:0]           num_neg;
    logic [MAG_W-1:0]      num_mag;
    logic [11:0]           dh_x;
    logic [11:0]           interp;

    assign job_load     = i_job[JOB_W-1];
    assign job_index    = i_job[P_IDX +: INDEX_W];
    assign job_voltage  = i_job[P_VLT +: VOLT_W];
    assign job_distance = i_job[P_DST +: DIST_W];
    assign job_sum      = i_job[P_SUM +: SUM_W];
    assign job_count    = i_job[CNT_W-1:0];

    always_comb begin
        if (i_piu < PIU_W'(2)) begin
            eff_p = PT_W'(2);
        end else if (int'(i_piu) > TABLE_DEPTH) begin
            eff_p = PT_W'(TABLE_DEPTH);
        end else begin
            eff_p = PT_W'(i_piu);
        end
    end
    assign last_idx = IDX_W'(eff_p - 1'b1);

    assign vl   = r_rd_data[ENT_W-1:DIST_W];
    assign dl   = r_rd_data[DIST_W-1:0];
    assign vl_x = SUM_W'(vl);
    assign vh_x = SUM_W'(r_vh);

    assign num_neg = -r_num;
    assign num_mag = r_num[21] ? num_neg[MAG_W-1:0] : r_num[MAG_W-1:0];
    assign dh_x    = {2'b00, r_dh};
    assign interp  = r_num[21] ? dh_x + {1'b0, div_q[DISTO_W-1:0]}
                               : dh_x - {1'b0, div_q[DISTO_W-1:0]};

    assign o_job_pop = (r_state == S_IDLE) && !i_queue_status.empty;
    assign div_start = (o_job_pop && !job_load) || (r_state == S_ISTART);

    always_comb begin
        if (r_state == S_ISTART) begin
            div_dividend = DIV_W'(num_mag);
            div_divisor  = DIV_W'(r_den);
        end else begin
            div_dividend = DIV_W'(job_sum);
            div_divisor  = DIV_W'(job_count);
        end
    end

    aapl_div #(
        .W(DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (div_q),
        .o_status   (div_st)
    );

    always_comb begin
        n_state = r_state;
        mem_we  = 1'b0;
        rd_en   = 1'b0;
        rd_addr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (o_job_pop) begin
                    if (job_load) begin
                        mem_we = (int'(job_index) < TABLE_DEPTH);
                    end else begin
                        n_state = S_MEAN;
                    end
                end
            end
            S_MEAN: begin
                if (div_st.done) begin
                    rd_en   = 1'b1;
                    n_state = S_FIRST;
                end
            end
            S_FIRST: begin
                if (r_mean >= vl_x) begin
                    n_state = S_EMIT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = IDX_W'(1);
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                priority if (r_mean == vh_x || r_mean == vl_x) begin
                    n_state = S_EMIT;
                end else if (r_mean <= vh_x && r_mean >= vl_x) begin
                    n_state = S_MUL;
                end else if (r_k == last_idx) begin
                    n_state = S_EMIT;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = IDX_W'(r_k + 1'b1);
                end
            end
            S_MUL:    n_state = S_ISTART;
            S_ISTART: n_state = S_IDIV;
            S_IDIV: begin
                if (div_st.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || pop) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[IDX_W'(job_index)] <= {job_voltage, job_distance};
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_MEAN: begin
                if (div_st.done) begin
                    r_mean <= div_q[SUM_W-1:0];
                end
            end
            S_FIRST: begin
                r_vh         <= vl;
                r_dh         <= dl;
                r_k          <= IDX_W'(1);
                r_res_dist   <= '0;
                r_res_status <= ST_NEAR;
            end
            S_WALK: begin
                priority if (r_mean == vh_x) begin
                    r_res_dist   <= {1'b0, r_dh};
                    r_res_status <= ST_WITHIN;
                end else if (r_mean == vl_x) begin
                    r_res_dist   <= {1'b0, dl};
                    r_res_status <= ST_WITHIN;
                end else if (r_mean <= vh_x && r_mean >= vl_x) begin
                    r_mdiff <= $signed({1'b0, r_mean[VOLT_W-1:0]}) - $signed({1'b0, r_vh});
                    r_ddiff <= $signed({1'b0, dl}) - $signed({1'b0, r_dh});
                    r_den   <= r_vh - vl;
                end else if (r_k == last_idx) begin
                    if (r_mean < vl_x) begin
                        r_res_dist   <= {1'b0, dl} + DISTO_W'(1);
                        r_res_status <= ST_BEYOND;
                    end else begin
                        r_res_dist   <= '0;
                        r_res_status <= ST_WITHIN;
                    end
                end else begin
                    r_vh <= vl;
                    r_dh <= dl;
                    r_k  <= IDX_W'(r_k + 1'b1);
                end
            end
            S_MUL: begin
                r_num <= r_mdiff * r_ddiff;
            end
            S_IDIV: begin
                if (div_st.done) begin
                    r_res_dist   <= interp[DISTO_W-1:0];
                    r_res_status <= ST_WITHIN;
                end
            end
            default: begin
            end
        endcase
    end

    assign out_take = pop && r_out_valid;
    assign out_load = (r_state == S_EMIT) && (!r_out_valid || pop);

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_dist   <= r_res_dist;
            r_out_status <= r_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign empty      = !r_out_valid;
    assign o_distance = r_out_dist;
    assign o_status   = r_out_status;

`ifndef SYNTHESIS
    a_div_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_st.busy)
        else $error("Divider started while busy.");
    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_st.done |-> (r_state == S_MEAN || r_state == S_IDIV))
        else $error("Divider finished with no state waiting for it.");
    a_walk_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_k != '0 && r_k <= last_idx))
        else $error("Table walk index out of range.");
    a_near_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_NEAR) |-> (r_out_dist == '0))
        else $error("Too near result with nonzero distance.");
`endif

endmodule

### rtl/adc_average_piecewise_linearizer.sv
// A load item is written to the table in the cycle after its transfer if the back end is idle.
// A reading's delay after its last sample's transfer is set by the bit-serial divider (DIV_W is 21
// with the default parameters), which forms the mean and the interpolation, and by the table walk.
// Throughput: one item per cycle is taken while the two-entry job queue has room.
// Readings are converted one at a time by the back end.
// Reset: synchronous, active low; clears the sum, count, queue and result; the table holds.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Averaging ADC piecewise linearizer
// Averages ADC samples and maps the mean to a distance through a
// piecewise linear calibration table.
// ----------------------------------------------------------------------------
module adc_average_piecewise_linearizer #(
    parameter int TABLE_DEPTH = aapl_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_SAMPLES = aapl_pkg::MAX_SAMPLES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [aapl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [aapl_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic                            i_command,
    input  logic [aapl_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic [aapl_pkg::INDEX_W-1:0]    i_point_index,
    input  logic [aapl_pkg::VOLT_W-1:0]     i_point_voltage,
    input  logic [aapl_pkg::DIST_W-1:0]     i_point_distance,
    output logic                            empty,
    input  logic                            pop,
    output logic [aapl_pkg::DISTO_W-1:0]    o_distance,
    output logic [aapl_pkg::STATUS_W-1:0]   o_status
);
    import aapl_pkg::*;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = SAMPLE_W + CNT_W;
    localparam int JOB_W = 1 + INDEX_W + VOLT_W + DIST_W + SUM_W + CNT_W;

    logic [SPR_W-1:0]   r_spr;
    logic [PIU_W-1:0]   r_piu;
    t_queue_status      q_status;
    logic               job_push;
    logic               job_pop;
    logic               job_load;
    logic [INDEX_W-1:0] job_index;
    logic [VOLT_W-1:0]  job_voltage;
    logic [DIST_W-1:0]  job_distance;
    logic [SUM_W-1:0]   job_sum;
    logic [CNT_W-1:0]   job_count;
    logic [JOB_W-1:0]   job_in;
    logic [JOB_W-1:0]   job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spr <= SPR_RESET;
            r_piu <= PIU_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SPR: r_spr <= i_cfg_data;
                CFG_PIU: r_piu <= i_cfg_data[PIU_W-1:0];
            endcase
        end
    end

    assign full   = q_status.full;
    assign job_in = {job_load, job_index, job_voltage, job_distance, job_sum, job_count};

    aapl_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .CNT_W       (CNT_W),
        .SUM_W       (SUM_W)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_spr            (r_spr),
        .push             (push),
        .i_command        (i_command),
        .i_sample         (i_sample),
        .i_point_index    (i_point_index),
        .i_point_voltage  (i_point_voltage),
        .i_point_distance (i_point_distance),
        .i_queue_status   (q_status),
        .o_job_push       (job_push),
        .o_job_load       (job_load),
        .o_job_index      (job_index),
        .o_job_voltage    (job_voltage),
        .o_job_distance   (job_distance),
        .o_job_sum        (job_sum),
        .o_job_count      (job_count)
    );

    aapl_queue #(
        .W(JOB_W)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (job_push),
        .i_data   (job_in),
        .i_pop    (job_pop),
        .o_data   (job_out),
        .o_status (q_status)
    );

    aapl_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_SAMPLES (MAX_SAMPLES),
        .CNT_W       (CNT_W),
        .SUM_W       (SUM_W),
        .JOB_W       (JOB_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_piu          (r_piu),
        .i_queue_status (q_status),
        .i_job          (job_out),
        .o_job_pop      (job_pop),
        .pop            (pop),
        .empty          (empty),
        .o_distance     (o_distance),
        .o_status       (o_status)
    );

endmodule
